// File: rtl/core/pmsm_pkg.sv
package pmsm_pkg;

    localparam int unsigned NUM_LINES = 4;
    localparam int unsigned NUM_COLS  = 8;

    localparam logic [6:0] RST_BASE_NOTE = 7'd36;
    localparam logic [3:0] RST_CHANNEL   = 4'd0;
    localparam logic [6:0] VEL_ON        = 7'd64;
    localparam logic [6:0] CTL_ASO       = 7'd120;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_CONTROL    = 4'hB;

    localparam logic [1:0] CFG_BASE_NOTE     = 2'd0;
    localparam logic [1:0] CFG_START_CHANNEL = 2'd1;

    localparam logic [2:0] EV_MIDI       = 3'd0;
    localparam logic [2:0] EV_LED_NORMAL = 3'd1;
    localparam logic [2:0] EV_LED_CONFIG = 3'd2;
    localparam logic [2:0] EV_DIMMER     = 3'd3;
    localparam logic [2:0] EV_BRIGHTER   = 3'd4;
    localparam logic [2:0] EV_LED_RESET  = 3'd5;
    localparam logic [2:0] EV_STORE_CH   = 3'd6;

    typedef logic [4:0] upc_t;

    localparam upc_t PC_IDLE    = 5'd0;
    localparam upc_t PC_DISP    = 5'd1;
    localparam upc_t PC_PRESS_Q = 5'd2;
    localparam upc_t PC_REL     = 5'd3;
    localparam upc_t PC_MODE    = 5'd4;
    localparam upc_t PC_PED     = 5'd5;
    localparam upc_t PC_ASO     = 5'd6;
    localparam upc_t PC_LEDCFG  = 5'd7;
    localparam upc_t PC_CFG     = 5'd8;
    localparam upc_t PC_CHSEL   = 5'd9;
    localparam upc_t PC_LINE3   = 5'd10;
    localparam upc_t PC_RISE4   = 5'd11;
    localparam upc_t PC_RISE0   = 5'd12;
    localparam upc_t PC_RISE2   = 5'd13;
    localparam upc_t PC_FIN     = 5'd14;
    localparam upc_t PC_CHAN    = 5'd15;
    localparam upc_t PC_RSTLOOP = 5'd16;
    localparam upc_t PC_DIM     = 5'd17;
    localparam upc_t PC_BRI     = 5'd18;
    localparam upc_t PC_STORE0  = 5'd19;
    localparam upc_t PC_LEDRST  = 5'd20;

    typedef logic [3:0] emit_t;
    localparam emit_t E_NONE    = 4'd0;
    localparam emit_t E_PEDAL   = 4'd1;
    localparam emit_t E_NOTEOFF = 4'd2;
    localparam emit_t E_ASO     = 4'd3;
    localparam emit_t E_LEDCFG  = 4'd4;
    localparam emit_t E_LEDNORM = 4'd5;
    localparam emit_t E_CHAN    = 4'd6;
    localparam emit_t E_STORE0  = 4'd7;
    localparam emit_t E_DIM     = 4'd8;
    localparam emit_t E_BRI     = 4'd9;
    localparam emit_t E_LEDRST  = 4'd10;

    typedef logic [2:0] act_t;
    localparam act_t A_NONE     = 3'd0;
    localparam act_t A_LOAD     = 3'd1;
    localparam act_t A_RELEASE  = 3'd2;
    localparam act_t A_SET_HELD = 3'd3;
    localparam act_t A_IDX_INC  = 3'd4;
    localparam act_t A_SET_CHAN = 3'd5;
    localparam act_t A_CHAN_0   = 3'd6;
    localparam act_t A_COMMIT   = 3'd7;

    typedef logic [3:0] cond_t;
    localparam cond_t C_ALWAYS   = 4'd0;
    localparam cond_t C_IN_ACC   = 4'd1;
    localparam cond_t C_SAME     = 4'd2;
    localparam cond_t C_BTN      = 4'd3;
    localparam cond_t C_LINE_LO  = 4'd4;
    localparam cond_t C_LINE3    = 4'd5;
    localparam cond_t C_RISE_ANY = 4'd6;
    localparam cond_t C_RISE4    = 4'd7;
    localparam cond_t C_RISE0    = 4'd8;
    localparam cond_t C_RISE2    = 4'd9;
    localparam cond_t C_IDX_L8   = 4'd10;
    localparam cond_t C_IDX_L32  = 4'd11;

    typedef struct packed {
        emit_t emit;
        act_t  act;
        cond_t cond;
        upc_t  tgt_t;
        upc_t  tgt_f;
    } uword_t;

    typedef struct packed {
        logic in_acc;
        logic same;
        logic btn;
        logic line_lo;
        logic line3;
        logic rise_any;
        logic rise4;
        logic rise0;
        logic rise2;
        logic idx_l8;
        logic idx_l32;
    } flags_t;

endpackage

// File: rtl/core/pmsm_useq.sv
module pmsm_useq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  pmsm_pkg::flags_t flags,
    output pmsm_pkg::uword_t uword,
    output pmsm_pkg::upc_t   pc
);

    function automatic pmsm_pkg::uword_t rom(input pmsm_pkg::upc_t a);
        pmsm_pkg::uword_t w;
        w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
              pmsm_pkg::PC_IDLE, pmsm_pkg::PC_IDLE};
        case (a)
            pmsm_pkg::PC_IDLE:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_LOAD, pmsm_pkg::C_IN_ACC,
                      pmsm_pkg::PC_DISP, pmsm_pkg::PC_IDLE};
            pmsm_pkg::PC_DISP:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_SAME,
                      pmsm_pkg::PC_MODE, pmsm_pkg::PC_PRESS_Q};
            pmsm_pkg::PC_PRESS_Q:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_BTN,
                      pmsm_pkg::PC_ASO, pmsm_pkg::PC_REL};
            pmsm_pkg::PC_REL:
                w = '{pmsm_pkg::E_LEDNORM, pmsm_pkg::A_RELEASE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_PED, pmsm_pkg::PC_PED};
            pmsm_pkg::PC_MODE:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_BTN,
                      pmsm_pkg::PC_CFG, pmsm_pkg::PC_PED};
            pmsm_pkg::PC_PED:
                w = '{pmsm_pkg::E_PEDAL, pmsm_pkg::A_IDX_INC, pmsm_pkg::C_IDX_L8,
                      pmsm_pkg::PC_FIN, pmsm_pkg::PC_PED};
            pmsm_pkg::PC_ASO:
                w = '{pmsm_pkg::E_ASO, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_LEDCFG, pmsm_pkg::PC_LEDCFG};
            pmsm_pkg::PC_LEDCFG:
                w = '{pmsm_pkg::E_LEDCFG, pmsm_pkg::A_SET_HELD, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_CFG, pmsm_pkg::PC_CFG};
            pmsm_pkg::PC_CFG:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_LINE_LO,
                      pmsm_pkg::PC_CHSEL, pmsm_pkg::PC_LINE3};
            pmsm_pkg::PC_CHSEL:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_RISE_ANY,
                      pmsm_pkg::PC_CHAN, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_LINE3:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_LINE3,
                      pmsm_pkg::PC_RISE4, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_RISE4:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_RISE4,
                      pmsm_pkg::PC_RSTLOOP, pmsm_pkg::PC_RISE0};
            pmsm_pkg::PC_RISE0:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_RISE0,
                      pmsm_pkg::PC_DIM, pmsm_pkg::PC_RISE2};
            pmsm_pkg::PC_RISE2:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_RISE2,
                      pmsm_pkg::PC_BRI, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_FIN:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_COMMIT, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_IDLE, pmsm_pkg::PC_IDLE};
            pmsm_pkg::PC_CHAN:
                w = '{pmsm_pkg::E_CHAN, pmsm_pkg::A_SET_CHAN, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_FIN, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_RSTLOOP:
                w = '{pmsm_pkg::E_NOTEOFF, pmsm_pkg::A_IDX_INC, pmsm_pkg::C_IDX_L32,
                      pmsm_pkg::PC_STORE0, pmsm_pkg::PC_RSTLOOP};
            pmsm_pkg::PC_DIM:
                w = '{pmsm_pkg::E_DIM, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_FIN, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_BRI:
                w = '{pmsm_pkg::E_BRI, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_FIN, pmsm_pkg::PC_FIN};
            pmsm_pkg::PC_STORE0:
                w = '{pmsm_pkg::E_STORE0, pmsm_pkg::A_CHAN_0, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_LEDRST, pmsm_pkg::PC_LEDRST};
            pmsm_pkg::PC_LEDRST:
                w = '{pmsm_pkg::E_LEDRST, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_FIN, pmsm_pkg::PC_FIN};
            default:
                w = '{pmsm_pkg::E_NONE, pmsm_pkg::A_NONE, pmsm_pkg::C_ALWAYS,
                      pmsm_pkg::PC_IDLE, pmsm_pkg::PC_IDLE};
        endcase
        return w;
    endfunction

    pmsm_pkg::upc_t pc_reg;
    pmsm_pkg::upc_t pc_next;
    logic           hit;

    assign uword = rom(pc_reg);
    assign pc    = pc_reg;

    always_comb
    begin
        case (uword.cond)
            pmsm_pkg::C_ALWAYS:   hit = 1'b1;
            pmsm_pkg::C_IN_ACC:   hit = flags.in_acc;
            pmsm_pkg::C_SAME:     hit = flags.same;
            pmsm_pkg::C_BTN:      hit = flags.btn;
            pmsm_pkg::C_LINE_LO:  hit = flags.line_lo;
            pmsm_pkg::C_LINE3:    hit = flags.line3;
            pmsm_pkg::C_RISE_ANY: hit = flags.rise_any;
            pmsm_pkg::C_RISE4:    hit = flags.rise4;
            pmsm_pkg::C_RISE0:    hit = flags.rise0;
            pmsm_pkg::C_RISE2:    hit = flags.rise2;
            pmsm_pkg::C_IDX_L8:   hit = flags.idx_l8;
            pmsm_pkg::C_IDX_L32:  hit = flags.idx_l32;
            default:              hit = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            pc_next = hit ? uword.tgt_t : uword.tgt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pmsm_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/core/pedal_matrix_scan_to_midi_core.sv
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     column_bits, config_button
// out      out  out_valid/out_ready   event_kind, status_byte, data_one, data_two, last_of_run
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One word at a time, stepped by a 21-entry microcode ROM. A pedal word runs the
// per-column loop over the 8 columns, after a release step when it leaves config
// mode; a config word may run a channel reset (32-step sweep over the stored bits).
// Events go through a one-deep pending stage so the last one can be flagged;
// output stalls hold the sequencer. Register writes are taken only while idle.
// Reset: channel 0, base note 36, all stored bits clear.
module pedal_matrix_scan_to_midi_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] column_bits,
    input  logic       config_button,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_kind,
    output logic [7:0] status_byte,
    output logic [6:0] data_one,
    output logic [6:0] data_two,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
    } evt_t;

    function automatic logic [2:0] low_idx(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    pmsm_pkg::uword_t uword;
    pmsm_pkg::upc_t   pc;
    pmsm_pkg::flags_t flags;
    logic             go;

    logic [6:0] base_reg;
    logic [3:0] chan_reg;
    logic [1:0] line_reg;
    logic       held_reg;
    logic [7:0] line_bits_reg [pmsm_pkg::NUM_LINES];
    logic [7:0] bits_reg;
    logic       btn_reg;
    logic [4:0] idx_reg;

    logic       pend_valid_reg;
    evt_t       pend_reg;
    logic       out_valid_reg;
    evt_t       out_reg;
    logic       last_reg;

    logic [1:0] rd_sel;
    logic [7:0] rd_row;
    logic [7:0] rise;
    logic [2:0] rise_low;
    logic [3:0] new_chan;
    logic [4:0] pedal_no;
    logic [6:0] note;
    logic       emit_eff;
    evt_t       new_evt;
    logic       commit;
    logic       push_need;
    logic       slot_free;

    pmsm_useq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .flags (flags),
        .uword (uword),
        .pc    (pc)
    );

    assign in_ready  = (pc == pmsm_pkg::PC_IDLE);
    assign cfg_ready = (pc == pmsm_pkg::PC_IDLE);

    assign rd_sel   = (uword.emit == pmsm_pkg::E_NOTEOFF) ? idx_reg[4:3] : line_reg;
    assign rd_row   = line_bits_reg[rd_sel];
    assign rise     = bits_reg & ~rd_row;
    assign rise_low = low_idx(rise);
    assign new_chan = {line_reg[0], rise_low};
    assign pedal_no = (uword.emit == pmsm_pkg::E_NOTEOFF) ? idx_reg
                                                         : {line_reg, idx_reg[2:0]};
    assign note     = base_reg + {2'b00, pedal_no};

    assign flags.in_acc   = in_valid;
    assign flags.same     = (btn_reg == held_reg);
    assign flags.btn      = btn_reg;
    assign flags.line_lo  = ~line_reg[1];
    assign flags.line3    = (line_reg == 2'd3);
    assign flags.rise_any = |rise;
    assign flags.rise4    = rise[4];
    assign flags.rise0    = rise[0];
    assign flags.rise2    = rise[2];
    assign flags.idx_l8   = (idx_reg[2:0] == 3'd7);
    assign flags.idx_l32  = (idx_reg == 5'd31);

    always_comb
    begin
        emit_eff = 1'b1;
        new_evt  = '{pmsm_pkg::EV_MIDI, 8'd0, 7'd0, 7'd0};
        case (uword.emit)
            pmsm_pkg::E_NONE:
            begin
                emit_eff = 1'b0;
            end
            pmsm_pkg::E_PEDAL:
            begin
                emit_eff = bits_reg[idx_reg[2:0]] ^ rd_row[idx_reg[2:0]];
                new_evt  = '{pmsm_pkg::EV_MIDI, {pmsm_pkg::ST_NOTE_ON, chan_reg}, note,
                             bits_reg[idx_reg[2:0]] ? pmsm_pkg::VEL_ON : 7'd0};
            end
            pmsm_pkg::E_NOTEOFF:
            begin
                emit_eff = rd_row[idx_reg[2:0]];
                new_evt  = '{pmsm_pkg::EV_MIDI, {pmsm_pkg::ST_NOTE_OFF, chan_reg}, note,
                             pmsm_pkg::VEL_ON};
            end
            pmsm_pkg::E_ASO:
            begin
                new_evt = '{pmsm_pkg::EV_MIDI, {pmsm_pkg::ST_CONTROL, chan_reg},
                            pmsm_pkg::CTL_ASO, 7'd0};
            end
            pmsm_pkg::E_LEDCFG:  new_evt.kind = pmsm_pkg::EV_LED_CONFIG;
            pmsm_pkg::E_LEDNORM: new_evt.kind = pmsm_pkg::EV_LED_NORMAL;
            pmsm_pkg::E_CHAN:
            begin
                new_evt.kind = pmsm_pkg::EV_STORE_CH;
                new_evt.d1   = {3'b000, new_chan};
            end
            pmsm_pkg::E_STORE0:  new_evt.kind = pmsm_pkg::EV_STORE_CH;
            pmsm_pkg::E_DIM:     new_evt.kind = pmsm_pkg::EV_DIMMER;
            pmsm_pkg::E_BRI:     new_evt.kind = pmsm_pkg::EV_BRIGHTER;
            pmsm_pkg::E_LEDRST:  new_evt.kind = pmsm_pkg::EV_LED_RESET;
            default:
            begin
                emit_eff = 1'b0;
            end
        endcase
    end

    assign commit    = (uword.act == pmsm_pkg::A_COMMIT);
    assign push_need = pend_valid_reg & (emit_eff | commit);
    assign slot_free = ~out_valid_reg | out_ready;
    assign go        = ~(push_need & ~slot_free);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= pmsm_pkg::RST_BASE_NOTE;
            chan_reg       <= pmsm_pkg::RST_CHANNEL;
            line_reg       <= 2'd0;
            held_reg       <= 1'b0;
            idx_reg        <= 5'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < pmsm_pkg::NUM_LINES; i++)
            begin
                line_bits_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pmsm_pkg::CFG_BASE_NOTE:     base_reg <= cfg_data;
                    pmsm_pkg::CFG_START_CHANNEL: chan_reg <= cfg_data[3:0];
                    default:                     ;
                endcase
            end

            if (go && push_need)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (go)
            begin
                if (emit_eff)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else if (commit)
                begin
                    pend_valid_reg <= 1'b0;
                end

                case (uword.act)
                    pmsm_pkg::A_LOAD:     idx_reg <= 5'd0;
                    pmsm_pkg::A_IDX_INC:  idx_reg <= idx_reg + 5'd1;
                    pmsm_pkg::A_SET_HELD: held_reg <= 1'b1;
                    pmsm_pkg::A_RELEASE:
                    begin
                        held_reg <= 1'b0;
                        for (int i = 0; i < pmsm_pkg::NUM_LINES; i++)
                        begin
                            line_bits_reg[i] <= 8'd0;
                        end
                    end
                    pmsm_pkg::A_SET_CHAN: chan_reg <= new_chan;
                    pmsm_pkg::A_CHAN_0:   chan_reg <= 4'd0;
                    pmsm_pkg::A_COMMIT:
                    begin
                        line_bits_reg[line_reg] <= bits_reg;
                        line_reg                <= line_reg + 2'd1;
                    end
                    default:              ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bits_reg <= column_bits;
            btn_reg  <= config_button;
        end
        if (go)
        begin
            if (push_need)
            begin
                out_reg  <= pend_reg;
                last_reg <= commit;
            end
            if (emit_eff)
            begin
                pend_reg <= new_evt;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = out_reg.kind;
    assign status_byte = out_reg.status;
    assign data_one    = out_reg.d1;
    assign data_two    = out_reg.d2;
    assign last_of_run = last_reg;

endmodule

// File: rtl/core/pmsm_checker.sv
module pmsm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_kind,
    input logic [7:0] status_byte,
    input logic [6:0] data_two
);

    // one word in flight: no back-to-back acceptance
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous word in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(status_byte))
        else $error("stalled output word changed");

    a_midi_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == pmsm_pkg::EV_MIDI |-> status_byte[7])
        else $error("MIDI event without status bit");

    a_non_midi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != pmsm_pkg::EV_MIDI |-> status_byte == 8'd0 && data_two == 7'd0)
        else $error("non-MIDI event carries MIDI payload");

endmodule

bind pedal_matrix_scan_to_midi_core pmsm_checker u_pmsm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .status_byte (status_byte),
    .data_two    (data_two)
);
